[rtl/lru_page_replacement_unit_assert.svh]
// Assertion macros for the LRU page replacement unit.
// Expanded inside a module that has clk and rst_n in scope.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUPR_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru page replacement: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRUPR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru page replacement: next-cycle check failed");

`endif

[rtl/lrupr_pkg.sv]
// Shared types and constants for the LRU page replacement unit.
// No dependencies; used by lrupr_cell and lru_page_replacement_unit.
package lrupr_pkg;

    // Fixed field widths of the ports.
    localparam int PAGE_NUMBER_W = 16;
    localparam int FRAME_INDEX_W = 3;
    localparam int FAULT_W       = 32;
    localparam int CFG_W         = 4;

    // Parameter defaults and reset values.
    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;
    localparam logic [CFG_W-1:0]   NUM_FRAMES_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX        = 32'hFFFF_FFFF;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } fsm_state_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic look;        // compare the incoming page and latch flags
        logic update;      // apply the replacement decision
        logic flush;       // clear valid bits and ranks
        logic mode_hit;    // the looked-up page is resident
        logic mode_empty;  // at least one active frame is empty
    } cell_ctrl_t;

    // Summary bits rippled along the row during a look.
    typedef struct packed {
        logic any_hit;
        logic any_empty;
    } look_link_t;

endpackage

[rtl/lrupr_cell.sv]
// One page frame of the LRU row: page, valid bit, recency rank and lookup flags.
// Depends on lrupr_pkg; chained by lru_page_replacement_unit.
module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int CELL_ID   = 0,
    parameter int IDX_W     = 3,
    parameter int RANK_W    = 3,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic                 active,
    input  logic [PAGE_BITS-1:0] look_page,
    input  logic [PAGE_BITS-1:0] new_page,
    input  logic [RANK_W-1:0]    last_rank,
    input  logic [RANK_W-1:0]    old_rank,
    input  look_link_t           look_in,
    input  logic [RANK_W-1:0]    hit_rank_in,
    output look_link_t           look_out,
    output logic [RANK_W-1:0]    hit_rank_out,
    input  logic                 taken_in,
    input  logic [IDX_W-1:0]     sel_idx_in,
    input  logic [PAGE_BITS-1:0] ev_page_in,
    output logic                 taken_out,
    output logic [IDX_W-1:0]     sel_idx_out,
    output logic [PAGE_BITS-1:0] ev_page_out
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg, valid_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic                 hit_flag_reg, empty_flag_reg, lru_flag_reg;

    logic hit_now, empty_now, lru_now;
    logic cand, sel, lru_mode;

    // Lookup of the incoming page against this frame.
    assign hit_now   = active && valid_reg && (page_reg == look_page);
    assign empty_now = active && !valid_reg;
    assign lru_now   = active && valid_reg && (rank_reg == last_rank);

    assign look_out.any_hit   = look_in.any_hit | hit_now;
    assign look_out.any_empty = look_in.any_empty | empty_now;
    assign hit_rank_out       = hit_rank_in | (hit_now ? rank_reg : '0);

    // Priority selection: the lowest-numbered candidate wins.
    assign lru_mode = !ctrl.mode_hit && !ctrl.mode_empty;
    assign cand     = ctrl.mode_hit   ? hit_flag_reg :
                      ctrl.mode_empty ? empty_flag_reg : lru_flag_reg;
    assign sel      = cand && !taken_in;

    assign taken_out   = taken_in | cand;
    assign sel_idx_out = sel_idx_in | (sel ? IDX_W'(CELL_ID) : '0);
    assign ev_page_out = ev_page_in | ((sel && lru_mode) ? page_reg : '0);

    // Next valid bit and rank.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (ctrl.flush)
        begin
            valid_next = 1'b0;
            rank_next  = '0;
        end
        else if (ctrl.update)
        begin
            if (sel)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
            end
            else if (valid_reg && (!ctrl.mode_hit || (rank_reg < old_rank)))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    // Control state of the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // Page store and lookup flags.
    always_ff @(posedge clk)
    begin
        if (ctrl.update && sel)
        begin
            page_reg <= new_page;
        end
        if (ctrl.look)
        begin
            hit_flag_reg   <= hit_now;
            empty_flag_reg <= empty_now;
            lru_flag_reg   <= lru_now;
        end
    end

endmodule

[rtl/lru_page_replacement_unit.sv]
// LRU page replacement unit: a row of frame cells with a two-state controller.
// A beat is compared against the row and its lookup latched when it is taken in ST_IDLE; the
// result register is written in ST_UPDATE, which waits for the output to be free and then
// ripples the victim choice along the cell row. No new reference is taken in ST_UPDATE.
// Reset: all frames invalid, ranks and fault counter zero, frame count 8, no
// clearing pass; a frame count write flushes all frames.
`include "lru_page_replacement_unit_assert.svh"

module lru_page_replacement_unit
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [PAGE_NUMBER_W-1:0] page_number,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit,
    output logic [FRAME_INDEX_W-1:0] frame_index,
    output logic                     evicted_valid,
    output logic [PAGE_NUMBER_W-1:0] evicted_page,
    output logic [FAULT_W-1:0]       fault_total,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(FRAMES + 1);

    fsm_state_t state_reg, state_next;
    cell_ctrl_t ctrl;

    logic [CFG_W-1:0]     num_frames_reg, num_frames_next;
    logic [CNT_W-1:0]     n_eff;
    logic [RANK_W-1:0]    last_rank;
    logic [PAGE_BITS-1:0] look_page;
    logic [PAGE_BITS-1:0] key_reg;
    logic                 hit_mode_reg, empty_mode_reg;
    logic [RANK_W-1:0]    old_rank_reg;
    logic [FAULT_W-1:0]   fault_reg, fault_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg;
    logic [FRAME_INDEX_W-1:0] frame_index_reg;
    logic                 evicted_valid_reg;
    logic [PAGE_NUMBER_W-1:0] evicted_page_reg;
    logic [FAULT_W-1:0]   fault_total_reg;

    logic in_accept, cfg_write, out_free;

    look_link_t           look_chain     [0:FRAMES];
    logic [RANK_W-1:0]    hit_rank_chain [0:FRAMES];
    logic                 taken_chain    [0:FRAMES];
    logic [IDX_W-1:0]     sel_idx_chain  [0:FRAMES];
    logic [PAGE_BITS-1:0] ev_page_chain  [0:FRAMES];
    logic [FRAMES-1:0]    active;

    assign in_accept = in_valid && !in_stall;
    assign cfg_write = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign look_page = PAGE_BITS'(page_number);

    // Effective frame count: zero acts as one, above FRAMES acts as FRAMES.
    always_comb
    begin
        if (num_frames_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(num_frames_reg) > FRAMES)
        begin
            n_eff = CNT_W'(FRAMES);
        end
        else
        begin
            n_eff = CNT_W'(num_frames_reg);
        end
    end

    assign last_rank = RANK_W'(n_eff - 1'b1);

    // Controller next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs and cell commands.
    always_comb
    begin
        in_stall        = 1'b1;
        cfg_ready       = 1'b0;
        ctrl.look       = 1'b0;
        ctrl.update     = 1'b0;
        ctrl.flush      = cfg_write;
        ctrl.mode_hit   = hit_mode_reg;
        ctrl.mode_empty = empty_mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = 1'b1;
                ctrl.look = in_valid;
            end
            ST_UPDATE:
            begin
                ctrl.update = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Row of frame cells, linked by the look and select chains.
    assign look_chain[0]     = '0;
    assign hit_rank_chain[0] = '0;
    assign taken_chain[0]    = 1'b0;
    assign sel_idx_chain[0]  = '0;
    assign ev_page_chain[0]  = '0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        assign active[i] = (n_eff > CNT_W'(i));

        lrupr_cell #(
            .CELL_ID   (i),
            .IDX_W     (IDX_W),
            .RANK_W    (RANK_W),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .active       (active[i]),
            .look_page    (look_page),
            .new_page     (key_reg),
            .last_rank    (last_rank),
            .old_rank     (old_rank_reg),
            .look_in      (look_chain[i]),
            .hit_rank_in  (hit_rank_chain[i]),
            .look_out     (look_chain[i+1]),
            .hit_rank_out (hit_rank_chain[i+1]),
            .taken_in     (taken_chain[i]),
            .sel_idx_in   (sel_idx_chain[i]),
            .ev_page_in   (ev_page_chain[i]),
            .taken_out    (taken_chain[i+1]),
            .sel_idx_out  (sel_idx_chain[i+1]),
            .ev_page_out  (ev_page_chain[i+1])
        );
    end

    // Frame count register and saturating fault counter.
    always_comb
    begin
        num_frames_next = cfg_write ? cfg_data : num_frames_reg;
        fault_next      = fault_reg;
        if (ctrl.update && !hit_mode_reg && (fault_reg != FAULT_MAX))
        begin
            fault_next = fault_reg + 1'b1;
        end
    end

    assign out_valid_next = ctrl.update ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_frames_reg <= NUM_FRAMES_RESET;
            fault_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_frames_reg <= num_frames_next;
            fault_reg      <= fault_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Lookup summary latched with the accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg        <= look_page;
            hit_mode_reg   <= look_chain[FRAMES].any_hit;
            empty_mode_reg <= look_chain[FRAMES].any_empty;
            old_rank_reg   <= hit_rank_chain[FRAMES];
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            hit_reg           <= hit_mode_reg;
            frame_index_reg   <= FRAME_INDEX_W'(sel_idx_chain[FRAMES]);
            evicted_valid_reg <= !hit_mode_reg && !empty_mode_reg;
            evicted_page_reg  <= PAGE_NUMBER_W'(ev_page_chain[FRAMES]);
            fault_total_reg   <= fault_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_total_reg;

    // Every update must find a frame to take the reference.
    `LRUPR_ASSERT_SAME(a_update_selects, ctrl.update, taken_chain[FRAMES])
    // A hit leaves the fault counter untouched.
    `LRUPR_ASSERT_NEXT(a_hit_no_fault, ctrl.update && hit_mode_reg, $stable(fault_reg))
    // The fault counter never moves backwards.
    `LRUPR_ASSERT_NEXT(a_fault_monotonic, 1'b1, fault_reg >= $past(fault_reg))

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lru_page_replacement_unit: directed table, then random references.
// Depends on lrupr_pkg and the unit itself; results are checked against an in-bench LRU predictor or typed table rows.

module testbench;
    import lrupr_pkg::*;

    localparam int MAX_FRAMES   = FRAMES_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 130;
    localparam int POOL_DEPTH   = 16;

    typedef enum logic {
        ROW_REFERENCE,
        ROW_FRAME_COUNT
    } row_kind_t;

    typedef struct packed {
        logic                     hit;
        logic [FRAME_INDEX_W-1:0] frame_index;
        logic                     evicted_valid;
        logic [PAGE_NUMBER_W-1:0] evicted_page;
        logic [FAULT_W-1:0]       fault_total;
    } lookup_result_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [PAGE_NUMBER_W-1:0] value;
        logic                     typed;
        lookup_result_t           result;
    } script_row_t;

    // Clock, reset and the ports of the unit.
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [PAGE_NUMBER_W-1:0] page_number = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic                     hit;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [PAGE_NUMBER_W-1:0] evicted_page;
    logic [FAULT_W-1:0]       fault_total;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_data    = '0;

    // Predictor state: a private copy of the frame table and its settings.
    logic [PAGE_NUMBER_W-1:0] model_page  [MAX_FRAMES];
    logic                     model_valid [MAX_FRAMES] = '{default: 1'b0};
    int                       model_rank  [MAX_FRAMES] = '{default: 0};
    logic [CFG_W-1:0]         model_frames = NUM_FRAMES_RESET;
    logic [FAULT_W-1:0]       model_faults = '0;

    lookup_result_t expected_lookups [$];
    script_row_t    script [$];
    int unsigned    tx_idle_pct    = 0;
    int unsigned    rx_idle_pct    = 0;
    int             mismatch_count = 0;
    int             quiet_cycles   = 0;

    always #1 clk = ~clk;

    lru_page_replacement_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Look the page up in the predicted table, apply the LRU update and return the result.
    function automatic lookup_result_t lookup_page(input logic [PAGE_NUMBER_W-1:0] pg);
        lookup_result_t r;
        int             active;
        int             slot;
        int             old_rank;
        logic           found;
        logic           have_empty;
        r          = '0;
        slot       = 0;
        found      = 1'b0;
        have_empty = 1'b0;
        active = (model_frames == 0) ? 1 :
                 (model_frames > MAX_FRAMES) ? MAX_FRAMES : int'(model_frames);
        for (int i = 0; i < active; i++)
        begin
            if (!found && model_valid[i] && model_page[i] == pg)
            begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            r.hit    = 1'b1;
            old_rank = model_rank[slot];
        end
        else
        begin
            for (int i = 0; i < active; i++)
            begin
                if (!have_empty && !model_valid[i])
                begin
                    slot       = i;
                    have_empty = 1'b1;
                end
            end
            if (have_empty)
            begin
                // Filling an empty frame pushes every resident frame back by one.
                old_rank = MAX_FRAMES + 1;
            end
            else
            begin
                // Victim is the lowest-numbered frame holding the oldest rank.
                slot = 0;
                for (int i = 1; i < active; i++)
                begin
                    if (model_rank[i] > model_rank[slot])
                        slot = i;
                end
                old_rank        = model_rank[slot];
                r.evicted_valid = 1'b1;
                r.evicted_page  = model_page[slot];
            end
            model_page[slot]  = pg;
            model_valid[slot] = 1'b1;
            if (model_faults != FAULT_MAX)
                model_faults = model_faults + 1'b1;
        end
        // The chosen frame becomes most recent; newer frames age by one.
        for (int i = 0; i < active; i++)
        begin
            if (i != slot && model_valid[i] && model_rank[i] < old_rank)
                model_rank[i] = model_rank[i] + 1;
        end
        model_rank[slot] = 0;
        r.frame_index    = FRAME_INDEX_W'(slot);
        r.fault_total    = model_faults;
        return r;
    endfunction

    function automatic script_row_t reference_row(input logic [PAGE_NUMBER_W-1:0] pg);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_REFERENCE;
        row.value = pg;
        return row;
    endfunction

    function automatic script_row_t known_row(input logic [PAGE_NUMBER_W-1:0] pg,
                                              input logic h, input int f, input logic ev,
                                              input logic [PAGE_NUMBER_W-1:0] evp,
                                              input logic [FAULT_W-1:0] ft);
        script_row_t row;
        row                      = reference_row(pg);
        row.typed                = 1'b1;
        row.result.hit           = h;
        row.result.frame_index   = FRAME_INDEX_W'(f);
        row.result.evicted_valid = ev;
        row.result.evicted_page  = evp;
        row.result.fault_total   = ft;
        return row;
    endfunction

    function automatic script_row_t count_row(input logic [CFG_W-1:0] count);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_FRAME_COUNT;
        row.value = PAGE_NUMBER_W'(count);
        return row;
    endfunction

    // Append one row to the end of the stimulus table.
    function automatic void add_row(input script_row_t row);
        script.insert(script.size(), row);
    endfunction

    // Offer one reference beat after a random gap and record its expected result once taken.
    task automatic send_reference(input logic [PAGE_NUMBER_W-1:0] pg, input logic typed,
                                  input lookup_result_t typed_result);
        lookup_result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= pg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = lookup_page(pg);
        expected_lookups.insert(expected_lookups.size(), typed ? typed_result : predicted);
    endtask

    // Write the frame count once every outstanding result has drained.
    task automatic set_frame_count(input logic [CFG_W-1:0] count);
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        model_frames = count;
        model_valid  = '{default: 1'b0};
        model_rank   = '{default: 0};
    endtask

    // Result side: check each taken beat against the oldest expectation, then roll the stall.
    always @(posedge clk)
    begin : result_check
        lookup_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_lookups.size() == 0)
            begin
                $error("result beat with no reference outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    mismatch_count++;
                end
                if (frame_index !== want.frame_index)
                begin
                    $error("frame_index: expected %0d, got %0d", want.frame_index, frame_index);
                    mismatch_count++;
                end
                if (evicted_valid !== want.evicted_valid)
                begin
                    $error("evicted_valid: expected %0d, got %0d",
                           want.evicted_valid, evicted_valid);
                    mismatch_count++;
                end
                if (evicted_page !== want.evicted_page)
                begin
                    $error("evicted_page: expected %h, got %h", want.evicted_page, evicted_page);
                    mismatch_count++;
                end
                if (fault_total !== want.fault_total)
                begin
                    $error("fault_total: expected %0d, got %0d", want.fault_total, fault_total);
                    mismatch_count++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Watchdog: give up when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: directed table first, then random phases over several frame counts.
    initial
    begin
        script_row_t              row;
        logic [PAGE_NUMBER_W-1:0] page_pool [POOL_DEPTH];
        logic [PAGE_NUMBER_W-1:0] pg;
        logic [PAGE_NUMBER_W-1:0] last_pg;
        logic [CFG_W-1:0]         count_value;
        logic [CFG_W-1:0]         phase_counts [PHASE_COUNT];
        int                       roll;
        int                       active;
        int                       pool_size;

        phase_counts = '{4'd3, 4'd8, 4'd1, 4'd9, 4'd6, 4'd0};
        last_pg      = '0;

        // Fill the eight frames from reset, then hit, evict and reuse.
        add_row(known_row(16'h0000, 1'b0, 0, 1'b0, 16'h0000, 32'd1));
        add_row(known_row(16'hFFFF, 1'b0, 1, 1'b0, 16'h0000, 32'd2));
        add_row(known_row(16'h0000, 1'b1, 0, 1'b0, 16'h0000, 32'd2));
        add_row(known_row(16'h5555, 1'b0, 2, 1'b0, 16'h0000, 32'd3));
        add_row(known_row(16'hAAAA, 1'b0, 3, 1'b0, 16'h0000, 32'd4));
        add_row(known_row(16'h00FF, 1'b0, 4, 1'b0, 16'h0000, 32'd5));
        add_row(known_row(16'hFF00, 1'b0, 5, 1'b0, 16'h0000, 32'd6));
        add_row(known_row(16'h0F0F, 1'b0, 6, 1'b0, 16'h0000, 32'd7));
        add_row(known_row(16'hF0F0, 1'b0, 7, 1'b0, 16'h0000, 32'd8));
        add_row(reference_row(16'h1234));
        add_row(reference_row(16'hFFFF));
        add_row(reference_row(16'h5555));
        add_row(reference_row(16'h8000));
        // A frame count of zero behaves as a single frame.
        add_row(count_row(4'd0));
        add_row(reference_row(16'h8001));
        add_row(reference_row(16'h8001));
        add_row(reference_row(16'h0001));
        // A frame count above the row size behaves as the full row.
        add_row(count_row(4'd15));
        add_row(reference_row(16'h0001));
        add_row(reference_row(16'h0002));
        add_row(reference_row(16'h0001));
        // Two frames: quick LRU eviction order.
        add_row(count_row(4'd2));
        add_row(reference_row(16'h00A0));
        add_row(reference_row(16'h00B0));
        add_row(reference_row(16'h00A0));
        add_row(reference_row(16'h00C0));
        add_row(reference_row(16'h00B0));
        add_row(reference_row(16'h00C0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 28;
        rx_idle_pct = 79;
        foreach (script[i])
        begin
            row = script[i];
            if (row.kind == ROW_FRAME_COUNT)
                set_frame_count(row.value[CFG_W-1:0]);
            else
                send_reference(row.value, row.typed, row.result);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            // Sender idles lightly first, then the receiver, then neither side idles.
            if (phase < 2)
            begin
                tx_idle_pct = 28;
                rx_idle_pct = 79;
            end
            else if (phase < 4)
            begin
                tx_idle_pct = 79;
                rx_idle_pct = 28;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            count_value = (phase == PHASE_COUNT - 1) ? CFG_W'($urandom_range(1, 15))
                                                     : phase_counts[phase];
            set_frame_count(count_value);
            active = (count_value == 0) ? 1 :
                     (count_value > MAX_FRAMES) ? MAX_FRAMES : int'(count_value);

            // A working set of the frame count plus up to four pages mixes hits with evictions.
            pool_size = active + $urandom_range(0, 4);
            for (int k = 0; k < POOL_DEPTH; k++)
                page_pool[k] = PAGE_NUMBER_W'($urandom);

            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    pg = page_pool[$urandom_range(0, pool_size - 1)];
                else if (roll < 85)
                    pg = last_pg;
                else
                    pg = PAGE_NUMBER_W'($urandom);
                send_reference(pg, 1'b0, '0);
                last_pg = pg;
            end
        end

        // Drain, then keep the clock running for any stray beat to show up.
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
